// ===== hdl/sarsa_pkg.sv =====
// Shared types, constants and saturation helpers for the SARSA value-table update unit.
package sarsa_pkg;

    localparam int STATE_W  = 5;
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = VALUE_W + COEF_W + 1;
    localparam int WIDE_W   = VALUE_W + 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [COEF_W-1:0] STEP_SIZE_RST = 16'd32768;
    localparam logic [COEF_W-1:0] DISCOUNT_RST  = 16'd58982;

    localparam logic REG_STEP_SIZE = 1'b0;
    localparam logic REG_DISCOUNT  = 1'b1;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic clr;
        logic load;
        logic mul_disc;
        logic td;
        logic mul_step;
        logic upd;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_stat;

    function automatic logic f_ovf(input logic signed [WIDE_W-1:0] x);
        return (x > WIDE_W'(VAL_MAX)) || (x < WIDE_W'(VAL_MIN));
    endfunction

    function automatic logic signed [VALUE_W-1:0] f_sat(input logic signed [WIDE_W-1:0] x);
        logic signed [VALUE_W-1:0] r;
        if (x > WIDE_W'(VAL_MAX)) begin
            r = VAL_MAX;
        end else if (x < WIDE_W'(VAL_MIN)) begin
            r = VAL_MIN;
        end else begin
            r = x[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/sarsa_regs.sv =====
// APB register block holding step size and discount.
module sarsa_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sarsa_pkg::ADDR_W-1:0]        paddr,
    input  logic [sarsa_pkg::DATA_W-1:0]        pwdata,
    output logic [sarsa_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [sarsa_pkg::COEF_W-1:0]        o_step_size,
    output logic [sarsa_pkg::COEF_W-1:0]        o_discount
);

    logic [sarsa_pkg::COEF_W-1:0] r_step_size;
    logic [sarsa_pkg::COEF_W-1:0] r_discount;
    logic                         w_wr;
    logic                         w_reg_sel;
    logic [sarsa_pkg::ADDR_W-3:0] w_unused_low;

    assign pready       = 1'b1;
    assign w_wr         = psel & penable & pwrite & pready;
    assign w_reg_sel    = paddr[2];
    assign w_unused_low = paddr[1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= sarsa_pkg::STEP_SIZE_RST;
            r_discount  <= sarsa_pkg::DISCOUNT_RST;
        end else if (w_wr) begin
            unique case (w_reg_sel)
                sarsa_pkg::REG_STEP_SIZE: r_step_size <= pwdata[sarsa_pkg::COEF_W-1:0];
                sarsa_pkg::REG_DISCOUNT:  r_discount  <= pwdata[sarsa_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            sarsa_pkg::REG_STEP_SIZE: prdata = {{(sarsa_pkg::DATA_W-sarsa_pkg::COEF_W){1'b0}},
                                                r_step_size};
            sarsa_pkg::REG_DISCOUNT:  prdata = {{(sarsa_pkg::DATA_W-sarsa_pkg::COEF_W){1'b0}},
                                                r_discount};
            default:                  prdata = {sarsa_pkg::DATA_W{w_unused_low[0]}};
        endcase
    end

    assign o_step_size = r_step_size;
    assign o_discount  = r_discount;

endmodule

// ===== hdl/sarsa_ctrl.sv =====
// Controller state machine sequencing table clear, read, multiply and write-back.
module sarsa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sarsa_pkg::t_dp_stat  i_stat,
    output sarsa_pkg::t_dp_cmd   o_cmd,
    output logic                 o_busy
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MUL1  = 6'b000100,
        S_TD    = 6'b001000,
        S_MUL2  = 6'b010000,
        S_UPD   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_disc = 1'b1;
                n_state        = S_TD;
            end
            S_TD: begin
                o_cmd.td = 1'b1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_step = 1'b1;
                n_state        = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/sarsa_dp.sv =====
// Datapath: value table memory, shared multiplier, TD error and update arithmetic.
module sarsa_dp #(
    parameter int NUM_STATES  = 32,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  sarsa_pkg::t_dp_cmd                          i_cmd,
    output sarsa_pkg::t_dp_stat                         o_stat,
    input  logic [sarsa_pkg::COEF_W-1:0]                i_step_size,
    input  logic [sarsa_pkg::COEF_W-1:0]                i_discount,
    input  logic                                        i_mode,
    input  logic [sarsa_pkg::STATE_W-1:0]               i_state_index,
    input  logic [sarsa_pkg::ACTION_W-1:0]              i_action,
    input  logic signed [sarsa_pkg::VALUE_W-1:0]        i_reward,
    input  logic [sarsa_pkg::STATE_W-1:0]               i_next_state_index,
    input  logic [sarsa_pkg::ACTION_W-1:0]              i_next_action,
    output logic                                        o_valid,
    output logic signed [sarsa_pkg::VALUE_W-1:0]        o_new_value,
    output logic signed [sarsa_pkg::VALUE_W-1:0]        o_td_error,
    output logic                                        o_saturated
);

    localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int AW     = $clog2(DEPTH);
    localparam int VW     = sarsa_pkg::VALUE_W;
    localparam int PW     = sarsa_pkg::PROD_W;
    localparam int WW     = sarsa_pkg::WIDE_W;
    localparam int CW     = sarsa_pkg::COEF_W;
    localparam int TERM_W = PW - CW;

    function automatic logic [AW-1:0] f_index(
        input logic [sarsa_pkg::STATE_W-1:0]  s,
        input logic [sarsa_pkg::ACTION_W-1:0] a
    );
        int sm;
        int am;
        sm = 0;
        am = 0;
        for (int i = 0; i < 2**sarsa_pkg::STATE_W; i++) begin
            if (s == sarsa_pkg::STATE_W'(i)) begin
                sm = i % NUM_STATES;
            end
        end
        for (int j = 0; j < 2**sarsa_pkg::ACTION_W; j++) begin
            if (a == sarsa_pkg::ACTION_W'(j)) begin
                am = j % NUM_ACTIONS;
            end
        end
        return AW'(sm * NUM_ACTIONS + am);
    endfunction

    logic signed [VW-1:0] r_mem [DEPTH];

    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        r_cur_idx;
    logic                 r_mode;
    logic signed [VW-1:0] r_reward;
    logic signed [VW-1:0] r_q_old;
    logic signed [VW-1:0] r_q_nxt;
    logic signed [PW-1:0] r_prod;
    logic signed [VW-1:0] r_delta;
    logic                 r_td_sat;
    logic                 r_valid;
    logic signed [VW-1:0] r_new_value;
    logic signed [VW-1:0] r_td_error;
    logic                 r_saturated;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic signed [VW-1:0]     w_wdata;
    logic signed [CW:0]       w_coef;
    logic signed [VW-1:0]     w_mul_b;
    logic signed [PW-1:0]     w_rnd;
    logic signed [TERM_W-1:0] w_term;
    logic signed [WW-1:0]     w_td_full;
    logic signed [WW-1:0]     w_upd_full;
    logic signed [VW-1:0]     w_new_val;
    logic                     w_upd_sat;

    // round half up, then floor shift back to Q16.16
    assign w_rnd  = r_prod + PW'(signed'(33'sd32768));
    assign w_term = w_rnd[PW-1:CW];

    assign w_coef  = i_cmd.mul_step ? signed'({1'b0, i_step_size}) : signed'({1'b0, i_discount});
    assign w_mul_b = i_cmd.mul_step ? r_delta : r_q_nxt;

    assign w_td_full = WW'(r_reward) - WW'(r_q_old) + (r_mode ? WW'(0) : WW'(w_term));
    assign w_upd_full = WW'(r_q_old) + WW'(w_term);
    assign w_new_val  = sarsa_pkg::f_sat(w_upd_full);
    assign w_upd_sat  = sarsa_pkg::f_ovf(w_upd_full);

    assign w_we    = i_cmd.clr | i_cmd.upd;
    assign w_waddr = i_cmd.clr ? r_clr_addr : r_cur_idx;
    assign w_wdata = i_cmd.clr ? '0 : w_new_val;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q_old <= r_mem[f_index(i_state_index, i_action)];
            r_q_nxt <= r_mem[f_index(i_next_state_index, i_next_action)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_idx <= f_index(i_state_index, i_action);
            r_mode    <= i_mode;
            r_reward  <= i_reward;
        end
        if (i_cmd.mul_disc || i_cmd.mul_step) begin
            r_prod <= w_coef * w_mul_b;
        end
        if (i_cmd.td) begin
            r_delta  <= sarsa_pkg::f_sat(w_td_full);
            r_td_sat <= sarsa_pkg::f_ovf(w_td_full);
        end
        if (i_cmd.upd) begin
            r_new_value <= w_new_val;
            r_td_error  <= r_delta;
            r_saturated <= r_td_sat | w_upd_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.upd;
            if (i_cmd.clr) begin
                r_clr_addr <= (r_clr_addr == AW'(DEPTH - 1)) ? '0 : r_clr_addr + AW'(1);
            end
        end
    end

    assign o_stat.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_valid         = r_valid;
    assign o_new_value     = r_new_value;
    assign o_td_error      = r_td_error;
    assign o_saturated     = r_saturated;

endmodule

// ===== hdl/tabular_sarsa_q_update_unit.sv =====
// Top level of the tabular SARSA TD(0) value-table update unit.
//
// Usage:
//   Drive the transition fields and pulse i_start while o_busy is low; the
//   transfer happens on that clock edge. The block then reads the current and
//   next table entries, forms the TD error and the updated entry on one shared
//   16x32 multiplier (discount term, then step term), and writes the entry back.
//   The result appears on o_new_value, o_td_error and o_saturated for exactly one
//   cycle with o_valid high; o_valid rises once the controller has passed
//   through S_MUL1, S_TD, S_MUL2 and S_UPD, and o_busy is low again in that
//   same cycle. No new item is taken before the last one is through; the
//   shared multiplier and the read-modify-write of the table make it so.
//   The receiver cannot stall; the result must be taken when o_valid is high.
//   Step size and discount sit on the APB port (offset 0 and 4); write them
//   only while the block is idle.
//   After reset the table is cleared one entry per cycle, holding o_busy high
//   until all NUM_STATES * NUM_ACTIONS entries (128 with the defaults) are
//   written; the APB registers return to 0.5 and about 0.90.
module tabular_sarsa_q_update_unit #(
    parameter int NUM_STATES  = 32,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [sarsa_pkg::ADDR_W-1:0]            paddr,
    input  logic [sarsa_pkg::DATA_W-1:0]            pwdata,
    output logic [sarsa_pkg::DATA_W-1:0]            prdata,
    output logic                                    pready,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic                                    i_mode,
    input  logic [sarsa_pkg::STATE_W-1:0]           i_state_index,
    input  logic [sarsa_pkg::ACTION_W-1:0]          i_action,
    input  logic signed [sarsa_pkg::VALUE_W-1:0]    i_reward,
    input  logic [sarsa_pkg::STATE_W-1:0]           i_next_state_index,
    input  logic [sarsa_pkg::ACTION_W-1:0]          i_next_action,
    output logic                                    o_valid,
    output logic signed [sarsa_pkg::VALUE_W-1:0]    o_new_value,
    output logic signed [sarsa_pkg::VALUE_W-1:0]    o_td_error,
    output logic                                    o_saturated
);

    logic [sarsa_pkg::COEF_W-1:0] w_step_size;
    logic [sarsa_pkg::COEF_W-1:0] w_discount;
    sarsa_pkg::t_dp_cmd           w_cmd;
    sarsa_pkg::t_dp_stat          w_stat;

    sarsa_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_step_size (w_step_size),
        .o_discount  (w_discount)
    );

    sarsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    sarsa_dp #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_step_size        (w_step_size),
        .i_discount         (w_discount),
        .i_mode             (i_mode),
        .i_state_index      (i_state_index),
        .i_action           (i_action),
        .i_reward           (i_reward),
        .i_next_state_index (i_next_state_index),
        .i_next_action      (i_next_action),
        .o_valid            (o_valid),
        .o_new_value        (o_new_value),
        .o_td_error         (o_td_error),
        .o_saturated        (o_saturated)
    );

endmodule

// ===== hdl/sarsa_chk.sv =====
// Port-level checker for the SARSA update unit, with its bind statement.
module sarsa_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    logic w_xfer;

    assign w_xfer = i_start & ~o_busy;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("block not busy after reset");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |=> o_busy)
        else $error("busy not raised after transfer");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |-> ##5 o_valid)
        else $error("result missing five cycles after transfer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("busy while result shown");

endmodule

bind tabular_sarsa_q_update_unit sarsa_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);

// ===== bench/sarsa_update_checker.sv =====
// Scoreboard for the SARSA update unit: mirrors the value table and checks every result.
`timescale 1ns / 100ps

package sarsa_tb_pkg;
    typedef enum logic {
        MODE_NORMAL   = 1'b0,
        MODE_TERMINAL = 1'b1
    } update_mode_e;
endpackage

module sarsa_update_checker
    import sarsa_pkg::*;
    import sarsa_tb_pkg::*;
#(
    parameter int NUM_STATES  = 32,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ADDR_W-1:0]                 paddr,
    input  logic [DATA_W-1:0]                 pwdata,
    input  logic                              pready,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_mode,
    input  logic [STATE_W-1:0]                i_state_index,
    input  logic [ACTION_W-1:0]               i_action,
    input  logic signed [VALUE_W-1:0]         i_reward,
    input  logic [STATE_W-1:0]                i_next_state_index,
    input  logic [ACTION_W-1:0]               i_next_action,
    input  logic                              i_valid,
    input  logic signed [VALUE_W-1:0]         i_new_value,
    input  logic signed [VALUE_W-1:0]         i_td_error,
    input  logic                              i_saturated,
    output int                                o_mismatches,
    output int                                o_pending
);

    typedef struct {
        logic signed [VALUE_W-1:0] new_value;
        logic signed [VALUE_W-1:0] td_error;
        logic                      saturated;
    } q_update_t;

    q_update_t                 update_q[$];
    logic signed [VALUE_W-1:0] q_table[NUM_STATES * NUM_ACTIONS];
    logic [COEF_W-1:0]         alpha;
    logic [COEF_W-1:0]         gamma;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Q0.16 x Q16.16, rounded half up back to Q16.16
    function automatic longint scale_q16(input logic [COEF_W-1:0] coef,
                                         input logic signed [VALUE_W-1:0] v);
        longint prod;
        prod = longint'(coef) * longint'(v);
        return (prod + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [VALUE_W-1:0] clamp32(input longint x, inout logic hit);
        logic signed [VALUE_W-1:0] r;
        if (x > longint'(VAL_MAX)) begin
            hit = 1'b1;
            r   = VAL_MAX;
        end else if (x < longint'(VAL_MIN)) begin
            hit = 1'b1;
            r   = VAL_MIN;
        end else begin
            r = x[VALUE_W-1:0];
        end
        return r;
    endfunction

    function automatic q_update_t predict_q_update();
        q_update_t                 res;
        longint                    full;
        logic                      hit;
        logic signed [VALUE_W-1:0] old_v;
        int                        cur;
        int                        nxt;
        hit   = 1'b0;
        cur   = int'(i_state_index) * NUM_ACTIONS + int'(i_action);
        nxt   = int'(i_next_state_index) * NUM_ACTIONS + int'(i_next_action);
        old_v = q_table[cur];
        full  = longint'(i_reward) - longint'(old_v);
        if (i_mode != MODE_TERMINAL) begin
            full += scale_q16(gamma, q_table[nxt]);
        end
        res.td_error  = clamp32(full, hit);
        res.new_value = clamp32(longint'(old_v) + scale_q16(alpha, res.td_error), hit);
        res.saturated = hit;
        q_table[cur]  = res.new_value;
        return res;
    endfunction

    always @(posedge i_clk) begin
        q_update_t exp_r;
        if (!i_rst_n) begin
            foreach (q_table[i]) q_table[i] = '0;
            alpha = STEP_SIZE_RST;
            gamma = DISCOUNT_RST;
            update_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (paddr[ADDR_W-1:2])
                    REG_STEP_SIZE: alpha = pwdata[COEF_W-1:0];
                    REG_DISCOUNT:  gamma = pwdata[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (update_q.size() == 0) begin
                    $error("result transfer with no update outstanding");
                    o_mismatches++;
                end else begin
                    exp_r = update_q.pop_front();
                    if (i_new_value !== exp_r.new_value) begin
                        $error("new_value: expected %0d, got %0d", exp_r.new_value, i_new_value);
                        o_mismatches++;
                    end
                    if (i_td_error !== exp_r.td_error) begin
                        $error("td_error: expected %0d, got %0d", exp_r.td_error, i_td_error);
                        o_mismatches++;
                    end
                    if (i_saturated !== exp_r.saturated) begin
                        $error("saturated: expected %0b, got %0b", exp_r.saturated,
                               i_saturated);
                        o_mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                update_q.push_back(predict_q_update());
            end
        end
        o_pending = update_q.size();
    end

endmodule

// ===== bench/tb.sv =====
// Stimulus and verdict for the SARSA value-table update unit.
`timescale 1ns / 100ps

module tb;
    import sarsa_pkg::*;
    import sarsa_tb_pkg::*;

    localparam logic [ADDR_W-1:0] STEP_ADDR = {REG_STEP_SIZE, 2'b00};
    localparam logic [ADDR_W-1:0] DISC_ADDR = {REG_DISCOUNT, 2'b00};

    logic                       i_clk              = 1'b0;
    logic                       i_rst_n            = 1'b0;
    logic                       psel               = 1'b0;
    logic                       penable            = 1'b0;
    logic                       pwrite             = 1'b0;
    logic [ADDR_W-1:0]          paddr              = '0;
    logic [DATA_W-1:0]          pwdata             = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       i_start            = 1'b0;
    logic                       o_busy;
    logic                       i_mode             = 1'b0;
    logic [STATE_W-1:0]         i_state_index      = '0;
    logic [ACTION_W-1:0]        i_action           = '0;
    logic signed [VALUE_W-1:0]  i_reward           = '0;
    logic [STATE_W-1:0]         i_next_state_index = '0;
    logic [ACTION_W-1:0]        i_next_action      = '0;
    logic                       o_valid;
    logic signed [VALUE_W-1:0]  o_new_value;
    logic signed [VALUE_W-1:0]  o_td_error;
    logic                       o_saturated;
    int                         mismatches;
    int                         pending;

    int          idle_pct;
    int          n_updates;
    int          n_terminal;
    int          n_settings;
    logic        in_episode;
    logic [4:0]  ep_state;
    logic [1:0]  ep_action;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tabular_sarsa_q_update_unit u_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_start, .o_busy, .i_mode, .i_state_index, .i_action, .i_reward,
        .i_next_state_index, .i_next_action, .o_valid, .o_new_value, .o_td_error,
        .o_saturated
    );

    sarsa_update_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_start, .i_busy(o_busy), .i_mode, .i_state_index, .i_action, .i_reward,
        .i_next_state_index, .i_next_action, .i_valid(o_valid),
        .i_new_value(o_new_value), .i_td_error(o_td_error), .i_saturated(o_saturated),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off until every outstanding update has returned
    task automatic wait_drained();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || o_busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_update(input update_mode_e mode, input logic [4:0] s,
                               input logic [1:0] a, input logic signed [31:0] r,
                               input logic [4:0] ns, input logic [1:0] na);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start            <= 1'b1;
        i_mode             <= mode;
        i_state_index      <= s;
        i_action           <= a;
        i_reward           <= r;
        i_next_state_index <= ns;
        i_next_action      <= na;
        do @(posedge i_clk); while (o_busy);
        n_updates++;
        if (mode == MODE_TERMINAL) n_terminal++;
    endtask

    function automatic logic [4:0] pick_state();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
    endfunction

    function automatic logic signed [31:0] pick_reward();
        logic signed [31:0] r;
        case ($urandom_range(0, 9))
            0:       r = VAL_MIN;
            1:       r = VAL_MAX;
            2, 3:    r = $urandom;
            default: r = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
        endcase
        return r;
    endfunction

    // mostly chained transitions, as in an episode; the rest is unrelated noise
    task automatic send_random_update();
        logic [4:0]   s;
        logic [4:0]   ns;
        logic [1:0]   a;
        logic [1:0]   na;
        update_mode_e m;
        if (in_episode && $urandom_range(0, 9) < 8) begin
            s = ep_state;
            a = ep_action;
        end else begin
            s = pick_state();
            a = 2'($urandom);
        end
        ns = pick_state();
        na = 2'($urandom);
        m  = ($urandom_range(0, 7) == 0) ? MODE_TERMINAL : MODE_NORMAL;
        send_update(m, s, a, pick_reward(), ns, na);
        in_episode = (m == MODE_NORMAL);
        ep_state   = ns;
        ep_action  = na;
    endtask

    task automatic run_segment(input logic [31:0] step_word, input logic [31:0] disc_word,
                               input int pct, input int count);
        wait_drained();
        reg_write(STEP_ADDR, step_word);
        reg_write(DISC_ADDR, disc_word);
        n_settings++;
        idle_pct = pct;
        repeat (count) send_random_update();
    endtask

    initial begin
        int guard;
        idle_pct   = 0;
        n_updates  = 0;
        n_terminal = 0;
        n_settings = 1;
        in_episode = 1'b0;
        ep_state   = '0;
        ep_action  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset settings, corner indices, full-scale rewards, saturation
        send_update(MODE_NORMAL,   5'd0,  2'd0, 32'sd0,  5'd0,  2'd0);
        send_update(MODE_NORMAL,   5'd31, 2'd3, VAL_MAX, 5'd31, 2'd3);
        send_update(MODE_NORMAL,   5'd31, 2'd3, VAL_MAX, 5'd31, 2'd3);
        send_update(MODE_NORMAL,   5'd31, 2'd3, VAL_MAX, 5'd31, 2'd3);
        send_update(MODE_TERMINAL, 5'd0,  2'd1, VAL_MIN, 5'd31, 2'd3);
        send_update(MODE_TERMINAL, 5'd0,  2'd1, VAL_MIN, 5'd0,  2'd0);
        send_update(MODE_TERMINAL, 5'd0,  2'd1, VAL_MIN, 5'd17, 2'd2);
        send_update(MODE_NORMAL,   5'd5,  2'd2, VAL_MAX, 5'd31, 2'd3);
        send_update(MODE_NORMAL,   5'd6,  2'd0, VAL_MIN, 5'd0,  2'd1);
        send_update(MODE_NORMAL,   5'd7,  2'd1, 32'sd1,  5'd5,  2'd2);
        send_update(MODE_NORMAL,   5'd7,  2'd1, -32'sd1, 5'd6,  2'd0);
        send_update(MODE_TERMINAL, 5'd8,  2'd2, 32'sh0000_8000, 5'd1, 2'd1);
        send_update(MODE_TERMINAL, 5'd8,  2'd2, -32'sh0000_8000, 5'd2, 2'd2);
        send_update(MODE_NORMAL,   5'd16, 2'd3, 32'sh0001_0000, 5'd8, 2'd2);
        send_update(MODE_NORMAL,   5'd15, 2'd0, 32'sh5555_5555, 5'd16, 2'd3);
        send_update(MODE_NORMAL,   5'd10, 2'd2, -32'sh2AAA_AAAB, 5'd10, 2'd2);
        send_update(MODE_NORMAL,   5'd10, 2'd2, 32'sh7FFF_0000, 5'd10, 2'd2);
        send_update(MODE_NORMAL,   5'd0,  2'd1, 32'sd0,  5'd0,  2'd1);

        run_segment(32'hDEAD_FFFF, 32'hBEEF_FFFF, 27, 160);
        run_segment($urandom, 32'h0000_0000, 27, 160);
        run_segment(32'h0000_0001, $urandom, 81, 160);
        run_segment(32'hFFFF_0000, $urandom, 81, 60);
        run_segment($urandom, $urandom, 0, 200);
        run_segment(32'h0000_8000, 32'h0000_E666, 0, 200);

        i_start <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 1000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (pending != 0) $error("%0d updates never produced a result", pending);
        $display("Covered %0d updates (%0d terminal) under %0d step-size/discount settings,",
                 n_updates, n_terminal, n_settings);
        $display("with chained transitions, full-scale rewards and saturating tables.");
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
